/* src/lpbw_pkg.sv */
// Shared types, constants and helpers for the LCD parallel bus writer.
`default_nettype none
package lpbw_pkg;

    // Request kinds as they arrive on the request channel
    typedef enum logic [1:0] {
        OP_CMD    = 2'd0,
        OP_DATA   = 2'd1,
        OP_PIXEL  = 2'd2,
        OP_WINDOW = 2'd3
    } t_op;

    // Display controller commands used by a window request
    localparam logic [7:0] CMD_COLUMN   = 8'h2A;
    localparam logic [7:0] CMD_ROW      = 8'h2B;
    localparam logic [7:0] CMD_MEMWRITE = 8'h2C;

    // Default request queue depth
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    localparam int unsigned STEP_W = 4;

    // Classified request: kind plus packed payload
    // coords = {x_start, y_start, x_end, y_end} for a window, else {48'b0, value}
    typedef struct packed {
        t_op         kind;
        logic [63:0] coords;
    } t_req;

    // Queue head as seen by the bus sequencer
    typedef struct packed {
        logic valid;
        t_req req;
    } t_head;

    // Step index of the final transfer for each request kind
    function automatic logic [STEP_W-1:0] last_step(input t_op kind);
        logic [STEP_W-1:0] s;
        case (kind)
            OP_CMD:    s = STEP_W'(0);
            OP_DATA:   s = STEP_W'(0);
            OP_PIXEL:  s = STEP_W'(1);
            OP_WINDOW: s = STEP_W'(10);
            default:   s = STEP_W'(0);
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

/* src/lpbw_if.sv */
// Handshake channels: display request in, bus byte transfer out.
`default_nettype none
interface lpbw_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [15:0] value;
    logic [15:0] x_start;
    logic [15:0] y_start;
    logic [15:0] x_end;
    logic [15:0] y_end;

    modport source (output valid, output op, output value, output x_start,
                    output y_start, output x_end, output y_end, input ready);
    modport sink   (input valid, input op, input value, input x_start,
                    input y_start, input x_end, input y_end, output ready);
endinterface

interface lpbw_xfer_if;
    logic       valid;
    logic       ready;
    logic [7:0] bus_byte;
    logic       is_data;
    logic       last;

    modport source (output valid, output bus_byte, output is_data, output last,
                    input ready);
    modport sink   (input valid, input bus_byte, input is_data, input last,
                    output ready);
endinterface
`default_nettype wire

/* src/lpbw_front.sv */
// Request front end: accepts requests and packs them for the queue.
`default_nettype none
module lpbw_front (
    lpbw_req_if.sink        i_req,
    input  logic            i_full,
    output logic            o_push,
    output lpbw_pkg::t_req  o_req
);
    import lpbw_pkg::*;

    t_op kind;

    // Accept whenever the queue has room
    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full;

    // Classify and pack; only a window uses the coordinates
    assign kind = t_op'(i_req.op);

    always_comb begin
        o_req.kind = kind;
        if (kind == OP_WINDOW) begin
            o_req.coords = {i_req.x_start, i_req.y_start, i_req.x_end, i_req.y_end};
        end else begin
            o_req.coords = {48'd0, i_req.value};
        end
    end

endmodule
`default_nettype wire

/* src/lpbw_queue.sv */
// Short request queue between the front end and the bus sequencer.
`default_nettype none
module lpbw_queue #(
    parameter int unsigned QUEUE_DEPTH = lpbw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lpbw_pkg::t_req  i_req,
    input  logic            i_pop,
    output logic            o_full,
    output lpbw_pkg::t_head o_head
);
    import lpbw_pkg::*;

    localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    t_req          r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign o_full       = (r_count == CW'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.req   = r_mem[r_rd_ptr];

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = i_push ? ptr_inc(r_wr_ptr) : r_wr_ptr;
        n_rd_ptr = i_pop  ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

endmodule
`default_nettype wire

/* src/lpbw_back.sv */
// Bus sequencer: walks each queued request and issues one byte transfer per cycle while the output is taken.
`default_nettype none
module lpbw_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lpbw_pkg::t_head    i_head,
    output logic               o_pop,
    lpbw_xfer_if.source        o_xfer
);
    import lpbw_pkg::*;

    logic [STEP_W-1:0] r_step, n_step;
    logic              r_vld;
    logic [7:0]        r_byte;
    logic              r_is_data;
    logic              r_last;

    logic              advance;
    logic              is_last;
    logic [63:0]       c;
    logic [7:0]        sel_byte;
    logic              sel_data;

    assign c       = i_head.req.coords;
    assign advance = i_head.valid && (!r_vld || o_xfer.ready);
    assign is_last = (r_step == last_step(i_head.req.kind));
    assign o_pop   = advance && is_last;
    assign n_step  = advance ? (is_last ? '0 : r_step + STEP_W'(1)) : r_step;

    // Byte for the current step; window order is column, x start/end, row, y start/end, memory write
    always_comb begin
        sel_byte = c[7:0];
        sel_data = 1'b1;
        case (i_head.req.kind)
            OP_CMD: begin
                sel_byte = c[7:0];
                sel_data = 1'b0;
            end
            OP_DATA: begin
                sel_byte = c[7:0];
            end
            OP_PIXEL: begin
                sel_byte = r_step[0] ? c[7:0] : c[15:8];
            end
            OP_WINDOW: begin
                case (r_step)
                    4'd0: begin
                        sel_byte = CMD_COLUMN;
                        sel_data = 1'b0;
                    end
                    4'd1: sel_byte = c[63:56];
                    4'd2: sel_byte = c[55:48];
                    4'd3: sel_byte = c[31:24];
                    4'd4: sel_byte = c[23:16];
                    4'd5: begin
                        sel_byte = CMD_ROW;
                        sel_data = 1'b0;
                    end
                    4'd6: sel_byte = c[47:40];
                    4'd7: sel_byte = c[39:32];
                    4'd8: sel_byte = c[15:8];
                    4'd9: sel_byte = c[7:0];
                    default: begin
                        sel_byte = CMD_MEMWRITE;
                        sel_data = 1'b0;
                    end
                endcase
            end
            default: begin
                sel_byte = c[7:0];
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_vld  <= 1'b0;
        end else begin
            r_step <= n_step;
            if (!r_vld || o_xfer.ready) begin
                r_vld <= i_head.valid;
            end
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_byte    <= sel_byte;
            r_is_data <= sel_data;
            r_last    <= is_last;
        end
    end

    assign o_xfer.valid    = r_vld;
    assign o_xfer.bus_byte = r_byte;
    assign o_xfer.is_data  = r_is_data;
    assign o_xfer.last     = r_last;

endmodule
`default_nettype wire

/* src/lcd_parallel_bus_writer_top.sv */
// Top level of the LCD parallel bus writer: front end, request queue, bus sequencer.
//
// Takes display requests (command byte, data byte, 16-bit pixel, set window) and
// turns them into byte transfers for an 8-bit parallel LCD bus with a data/command
// select; the final transfer of each request carries last. A request can be
// accepted every cycle while the queue (QUEUE_DEPTH entries) has room. The bus
// sequencer issues one transfer per cycle whenever the output is taken; a command
// or data byte needs one transfer, a pixel two and a window eleven. The first
// transfer of a request passes through the queue storage and the output register
// before it shows on the output.
// Reset is synchronous, active low.
`default_nettype none
module lcd_parallel_bus_writer_top #(
    parameter int unsigned QUEUE_DEPTH = lpbw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lpbw_req_if.sink     i_req,
    lpbw_xfer_if.source  o_xfer
);
    import lpbw_pkg::*;

    logic  push;
    logic  pop;
    logic  full;
    t_req  req;
    t_head head;

    lpbw_front u_front (
        .i_req  (i_req),
        .i_full (full),
        .o_push (push),
        .o_req  (req)
    );

    lpbw_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (req),
        .i_pop   (pop),
        .o_full  (full),
        .o_head  (head)
    );

    lpbw_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_xfer  (o_xfer)
    );

endmodule
`default_nettype wire

/* src/lpbw_checker.sv */
// Port-level checks for the LCD parallel bus writer, bound to the top level.
`default_nettype none
module lpbw_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_bus_byte,
    input logic       i_out_is_data,
    input logic       i_out_last
);
    import lpbw_pkg::*;

    // Reset leaves no transfer pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("transfer valid right after reset");

    // A stalled transfer stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("transfer dropped while stalled");

    // A stalled transfer keeps its payload
    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
        $stable(i_out_bus_byte) && $stable(i_out_is_data) && $stable(i_out_last))
        else $error("transfer payload changed while stalled");

    // Only the column and row commands of a window are commands that do not end a request
    a_mid_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_is_data && !i_out_last |->
        (i_out_bus_byte == CMD_COLUMN) || (i_out_bus_byte == CMD_ROW))
        else $error("unexpected non-final command transfer");

endmodule

bind lcd_parallel_bus_writer_top lpbw_checker u_lpbw_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_xfer.valid),
    .i_out_ready    (o_xfer.ready),
    .i_out_bus_byte (o_xfer.bus_byte),
    .i_out_is_data  (o_xfer.is_data),
    .i_out_last     (o_xfer.last)
);
`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench for the LCD parallel bus writer: random and directed requests.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lpbw_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned DRAIN_CYCLES = 20;
    localparam int unsigned MAX_REPORTS = 40;

    // One display request as the driver holds it
    typedef struct {
        t_op         op;
        logic [15:0] value;
        logic [15:0] x_start;
        logic [15:0] y_start;
        logic [15:0] x_end;
        logic [15:0] y_end;
    } t_lcd_req;

    // One bus write strobe
    typedef struct packed {
        logic [7:0] bus_byte;
        logic       is_data;
        logic       last;
    } t_bus_xfer;

    logic i_clk;
    logic i_rst_n;

    lpbw_req_if  rq();
    lpbw_xfer_if xf();

    lcd_parallel_bus_writer_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (rq),
        .o_xfer  (xf)
    );

    t_lcd_req    pending_reqs[$];
    t_bus_xfer   expected_xfers[$];
    bit          req_in_flight;
    bit          req_fired;
    int unsigned src_idle_pct;
    int unsigned snk_idle_pct;
    int unsigned cycle_count;
    int unsigned mismatch_count;
    int unsigned xfers_checked;
    int unsigned reqs_by_kind[4];

    // Clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // One line per mismatch, capped so a broken build does not flood the log
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] MISMATCH: %s", $time, msg);
        end
    endtask

    function automatic void push_xfer(input logic [7:0] b, input logic d, input logic l);
        t_bus_xfer x;
        x.bus_byte = b;
        x.is_data  = d;
        x.last     = l;
        expected_xfers.push_back(x);
    endfunction

    // Bus transfers that one request turns into, in bus order
    function automatic void expand_request(input t_lcd_req r);
        case (r.op)
            OP_CMD: begin
                push_xfer(r.value[7:0], 1'b0, 1'b1);
            end
            OP_DATA: begin
                push_xfer(r.value[7:0], 1'b1, 1'b1);
            end
            OP_PIXEL: begin
                push_xfer(r.value[15:8], 1'b1, 1'b0);
                push_xfer(r.value[7:0], 1'b1, 1'b1);
            end
            default: begin
                // column range, row range, then memory write
                push_xfer(CMD_COLUMN, 1'b0, 1'b0);
                push_xfer(r.x_start[15:8], 1'b1, 1'b0);
                push_xfer(r.x_start[7:0], 1'b1, 1'b0);
                push_xfer(r.x_end[15:8], 1'b1, 1'b0);
                push_xfer(r.x_end[7:0], 1'b1, 1'b0);
                push_xfer(CMD_ROW, 1'b0, 1'b0);
                push_xfer(r.y_start[15:8], 1'b1, 1'b0);
                push_xfer(r.y_start[7:0], 1'b1, 1'b0);
                push_xfer(r.y_end[15:8], 1'b1, 1'b0);
                push_xfer(r.y_end[7:0], 1'b1, 1'b0);
                push_xfer(CMD_MEMWRITE, 1'b0, 1'b1);
            end
        endcase
    endfunction

    // Request driver: one request at a time from the pending queue
    always @(negedge i_clk) begin : req_driver
        t_lcd_req cur;
        if (!i_rst_n) begin
            rq.valid <= 1'b0;
        end else begin
            if (req_in_flight && req_fired) req_in_flight = 1'b0;
            if (!req_in_flight && pending_reqs.size() > 0 &&
                $urandom_range(99) >= src_idle_pct) begin
                cur = pending_reqs.pop_front();
                req_in_flight = 1'b1;
                rq.op      <= cur.op;
                rq.value   <= cur.value;
                rq.x_start <= cur.x_start;
                rq.y_start <= cur.y_start;
                rq.x_end   <= cur.x_end;
                rq.y_end   <= cur.y_end;
            end
            rq.valid <= req_in_flight;
        end
    end

    // Bus side: random back-pressure
    always @(negedge i_clk) begin
        xf.ready <= i_rst_n && ($urandom_range(99) >= snk_idle_pct);
    end

    // Monitor: check transfers, then predict from the accepted request
    always @(posedge i_clk) begin : monitor
        t_bus_xfer want;
        t_lcd_req  r;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[%0t] timeout after %0d cycles", $time, cycle_count);
            $display("status: fail");
            $finish;
        end
        req_fired <= i_rst_n && rq.valid && rq.ready;
        if (i_rst_n) begin
            if (xf.valid && xf.ready) begin
                xfers_checked++;
                if (expected_xfers.size() == 0) begin
                    report_mismatch($sformatf("unexpected transfer byte=%02h dc=%0b last=%0b",
                                              xf.bus_byte, xf.is_data, xf.last));
                end else begin
                    want = expected_xfers.pop_front();
                    if (xf.bus_byte !== want.bus_byte)
                        report_mismatch($sformatf("bus_byte %02h, want %02h",
                                                  xf.bus_byte, want.bus_byte));
                    if (xf.is_data !== want.is_data)
                        report_mismatch($sformatf("is_data %0b, want %0b (byte %02h)",
                                                  xf.is_data, want.is_data, want.bus_byte));
                    if (xf.last !== want.last)
                        report_mismatch($sformatf("last %0b, want %0b (byte %02h)",
                                                  xf.last, want.last, want.bus_byte));
                end
            end
            if (rq.valid && rq.ready) begin
                r.op      = t_op'(rq.op);
                r.value   = rq.value;
                r.x_start = rq.x_start;
                r.y_start = rq.y_start;
                r.x_end   = rq.x_end;
                r.y_end   = rq.y_end;
                reqs_by_kind[rq.op]++;
                expand_request(r);
            end
        end
    end

    task automatic queue_req(input t_op op, input logic [15:0] value,
                             input logic [15:0] xs, input logic [15:0] ys,
                             input logic [15:0] xe, input logic [15:0] ye);
        t_lcd_req r;
        r.op      = op;
        r.value   = value;
        r.x_start = xs;
        r.y_start = ys;
        r.x_end   = xe;
        r.y_end   = ye;
        pending_reqs.push_back(r);
    endtask

    // Sender holds off until every queued request has been fully sent
    task automatic wait_drained();
        while (pending_reqs.size() > 0 || req_in_flight || expected_xfers.size() > 0)
            @(posedge i_clk);
    endtask

    // Random 16-bit field, biased toward the extremes now and then
    function automatic logic [15:0] rand_word();
        int unsigned pick;
        pick = $urandom_range(19);
        if (pick == 0) return 16'h0000;
        if (pick == 1) return 16'hFFFF;
        return 16'($urandom());
    endfunction

    function automatic t_op rand_op();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 20) return OP_CMD;
        if (pick < 40) return OP_DATA;
        if (pick < 80) return OP_PIXEL;
        return OP_WINDOW;
    endfunction

    task automatic queue_random(input int unsigned n);
        for (int unsigned k = 0; k < n; k++)
            queue_req(rand_op(), rand_word(), rand_word(), rand_word(), rand_word(),
                      rand_word());
    endtask

    // Stimulus and end of run
    initial begin
        i_rst_n    = 1'b0;
        rq.valid   = 1'b0;
        rq.op      = OP_CMD;
        rq.value   = '0;
        rq.x_start = '0;
        rq.y_start = '0;
        rq.x_end   = '0;
        rq.y_end   = '0;
        xf.ready   = 1'b0;
        src_idle_pct = 21;
        snk_idle_pct = 69;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: byte extremes, ignored upper bits and coordinates
        queue_req(OP_CMD, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        queue_req(OP_CMD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_req(OP_CMD, 16'hA52A, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0);
        queue_req(OP_DATA, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
        queue_req(OP_DATA, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
        queue_req(OP_DATA, 16'h5A81, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
        // Pixels: extremes and single-bit patterns across the byte split
        queue_req(OP_PIXEL, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_req(OP_PIXEL, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        queue_req(OP_PIXEL, 16'h8001, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        queue_req(OP_PIXEL, 16'h7FFE, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        queue_req(OP_PIXEL, 16'h00FF, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        queue_req(OP_PIXEL, 16'hFF00, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        // Windows: all zero, all ones, start past end, distinct bytes
        queue_req(OP_WINDOW, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        queue_req(OP_WINDOW, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_req(OP_WINDOW, 16'h0000, 16'h00EF, 16'h013F, 16'h0000, 16'h0000);
        queue_req(OP_WINDOW, 16'h1234, 16'h0102, 16'h0304, 16'h0506, 16'h0708);
        queue_req(OP_WINDOW, 16'h0000, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA);
        queue_req(OP_WINDOW, 16'h0000, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555);
        // Back-to-back mix of kinds
        queue_req(OP_PIXEL, 16'hF81F, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        queue_req(OP_CMD, 16'h002C, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        queue_req(OP_WINDOW, 16'h0000, 16'h0010, 16'h0020, 16'h0010, 16'h0020);
        queue_req(OP_DATA, 16'h0036, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        queue_random(60);
        wait_drained();

        // Sender mostly idle, bus side mostly ready
        src_idle_pct = 69;
        snk_idle_pct = 21;
        queue_random(70);
        wait_drained();

        // Full rate on both sides
        src_idle_pct = 0;
        snk_idle_pct = 0;
        queue_random(70);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_xfers.size() > 0)
            report_mismatch($sformatf("%0d transfers never arrived", expected_xfers.size()));

        $display("covered %0d requests: %0d command, %0d data, %0d pixel, %0d window",
                 reqs_by_kind[0] + reqs_by_kind[1] + reqs_by_kind[2] + reqs_by_kind[3],
                 reqs_by_kind[OP_CMD], reqs_by_kind[OP_DATA], reqs_by_kind[OP_PIXEL],
                 reqs_by_kind[OP_WINDOW]);
        $display("checked %0d bus transfers under three back-pressure mixes, %0d mismatches",
                 xfers_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
